>>> rtl/core/running_center_point_clusterer_unit_macros.svh
// Assertion macros for the running center-point clusterer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef RUNNING_CENTER_POINT_CLUSTERER_UNIT_MACROS_SVH
`define RUNNING_CENTER_POINT_CLUSTERER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every edge outside reset
`define RCPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rcpc check failed");
// Antecedent implies consequent in the next cycle
`define RCPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcpc check failed");
`else
`define RCPC_ASSERT(name, clk, rst_n, prop)
`define RCPC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/rcpc_pkg.sv
// Shared constants and types of the running center-point clusterer.
// No dependencies; used by all modules in rtl/core.
`default_nettype none

package rcpc_pkg;

  // Fixed-point format of positions
  localparam int IntBits   = 32;
  localparam int FracBits  = 8;
  localparam int PosBits   = IntBits + FracBits;
  localparam int JdBits    = 32;
  localparam int CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Compare width holds both the center plus distance and the position
  localparam int CmpBits = ((PosBits > JdBits + FracBits) ? PosBits : JdBits + FracBits) + 1;

  // Stream widths, rounded up to whole bytes
  localparam int InDataBits  = ((PosBits + 7) / 8) * 8;
  localparam int OutRawBits  = PosBits + 2 * IntBits + CountBits;
  localparam int OutDataBits = ((OutRawBits + 7) / 8) * 8;

  // Result queue
  localparam int FifoDepth = 4;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int CntBits   = $clog2(FifoDepth + 1);

  localparam logic [JdBits-1:0] JoinDistanceReset = JdBits'(1);

  typedef struct packed {
    logic [CountBits-1:0] count;
    logic [IntBits-1:0]   high;
    logic [IntBits-1:0]   low;
    logic [PosBits-1:0]   center;
  } cluster_t;

  typedef struct packed {
    logic     done;
    logic     last;
    cluster_t clu;
  } result_t;

  // Per-item update from the step logic to the top level
  typedef struct packed {
    logic       open;
    cluster_t   clu;
    logic [1:0] push_n;
    result_t    row0;
    result_t    row1;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/rcpc_step.sv
// Per-point cluster update: join test, center average, bounds and count.
// Depends on rcpc_pkg.
`default_nettype none

module rcpc_step (
  input  wire logic                         open_i,
  input  wire rcpc_pkg::cluster_t           clu_i,
  input  wire logic [rcpc_pkg::PosBits-1:0] pos_i,
  input  wire logic                         eos_i,
  input  wire logic [rcpc_pkg::JdBits-1:0]  jd_i,
  output rcpc_pkg::step_t                   step_o
);

  logic [rcpc_pkg::CmpBits-1:0]  limit;
  logic                          joins;
  logic [rcpc_pkg::PosBits:0]    sum;
  logic [rcpc_pkg::IntBits-1:0]  ip;
  rcpc_pkg::cluster_t            one_pt;
  rcpc_pkg::cluster_t            merged;
  rcpc_pkg::cluster_t            cur;
  logic                          closed;

  // Join when position is below center plus the scaled distance
  assign limit = rcpc_pkg::CmpBits'(clu_i.center)
               + rcpc_pkg::CmpBits'({jd_i, {rcpc_pkg::FracBits{1'b0}}});
  assign joins = rcpc_pkg::CmpBits'(pos_i) < limit;

  // Floor of the mean of center and point
  assign sum = (rcpc_pkg::PosBits+1)'(clu_i.center) + (rcpc_pkg::PosBits+1)'(pos_i);
  assign ip  = pos_i[rcpc_pkg::PosBits-1:rcpc_pkg::FracBits];

  always_comb begin
    one_pt.center = pos_i;
    one_pt.low    = ip;
    one_pt.high   = ip;
    one_pt.count  = rcpc_pkg::CountBits'(1);

    merged.center = sum[rcpc_pkg::PosBits:1];
    merged.low    = (ip < clu_i.low)  ? ip : clu_i.low;
    merged.high   = (ip > clu_i.high) ? ip : clu_i.high;
    merged.count  = (clu_i.count == rcpc_pkg::CountMax) ? clu_i.count
                                                        : clu_i.count + 1'b1;
  end

  // Pick the cluster after this point; a far point closes the open one
  always_comb begin
    closed = 1'b0;
    cur    = one_pt;
    if (open_i) begin
      if (joins) begin
        cur = merged;
      end else begin
        closed = 1'b1;
      end
    end
  end

  // Results in order: closed cluster first, then the flushed one
  always_comb begin
    step_o.row1.clu  = cur;
    step_o.row1.last = 1'b1;
    step_o.row1.done = 1'b1;
    if (closed) begin
      step_o.row0.clu  = clu_i;
      step_o.row0.last = !eos_i;
      step_o.row0.done = 1'b0;
    end else begin
      step_o.row0 = step_o.row1;
    end
    step_o.push_n = {1'b0, closed} + {1'b0, eos_i};
    step_o.open   = !eos_i;
    step_o.clu    = eos_i ? '0 : cur;
  end

endmodule

`default_nettype wire

>>> rtl/core/rcpc_fifo.sv
// Result queue taking up to two results per cycle and giving one per transfer.
// Depends on rcpc_pkg.
`default_nettype none

module rcpc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire rcpc_pkg::result_t row0_i,
  input  wire rcpc_pkg::result_t row1_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rcpc_pkg::result_t      row_o
);

  rcpc_pkg::result_t              mem_q [rcpc_pkg::FifoDepth];
  logic [rcpc_pkg::PtrBits-1:0]   wr_q, rd_q, wr_d, rd_d, wr_nx;
  logic [rcpc_pkg::CntBits-1:0]   cnt_q, cnt_d;
  logic                           pop;

  assign valid_o = cnt_q != '0;
  assign row_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign space_o = cnt_q <= rcpc_pkg::CntBits'(rcpc_pkg::FifoDepth - 2);
  assign wr_nx   = wr_q + 1'b1;

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + rcpc_pkg::PtrBits'(push_n_i);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + rcpc_pkg::CntBits'(push_n_i) - rcpc_pkg::CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store one or two results
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= row0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nx] <= row1_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/running_center_point_clusterer_unit.sv
// Running center-point clusterer, top level.
// Depends on rcpc_pkg, rcpc_step, rcpc_fifo and the assertion macro header.
//
// Usage:
//   Slave stream: one point per transfer, tdata[39:0] = position (Q32.8),
//   tlast = end of set. Master stream: one closed cluster per transfer,
//   tdata = center[39:0], low[71:40], high[103:72], count[119:104];
//   tlast = last result of the point, tuser[0] = set flushed.
//   Config channel: write join_distance (integer, reset value 1) while idle.
// Timing:
//   A point is folded into the open cluster in the cycle it is taken; its
//   results are offered on the master side from the next cycle on.
//   One point per cycle is taken while at most two results sit in the
//   four-entry result queue; a point closing and flushing makes two results,
//   which drain one per cycle through one output port while tready is high.
// Reset: no cluster is open, the queue is empty, join_distance returns to 1.
// Stall: when the receiver holds tready low the queue fills and tready on
//   the slave side drops; no result is lost or repeated.
`default_nettype none
`include "running_center_point_clusterer_unit_macros.svh"

module running_center_point_clusterer_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // position[39:0]
  input  wire logic [rcpc_pkg::InDataBits-1:0]  s_axis_tdata_i,
  input  wire logic                             s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // cluster_center[39:0], cluster_low[71:40], cluster_high[103:72],
  // member_count[119:104]
  output logic [rcpc_pkg::OutDataBits-1:0]      m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  // set_done[0]
  output logic [0:0]                            m_axis_tuser_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rcpc_pkg::JdBits-1:0]      cfg_data_i
);

  logic                          open_q;
  rcpc_pkg::cluster_t            clu_q;
  logic [rcpc_pkg::JdBits-1:0]   jd_q;
  logic                          s_fire;
  logic                          space;
  logic [1:0]                    push_n;
  rcpc_pkg::step_t               step;
  rcpc_pkg::result_t             out_row;

  assign s_axis_tready_o = space;
  assign s_fire          = s_axis_tvalid_i && space;
  assign cfg_ready_o     = 1'b1;

  // Cluster update for the point on the slave side
  rcpc_step u_step (
    .open_i (open_q),
    .clu_i  (clu_q),
    .pos_i  (s_axis_tdata_i[rcpc_pkg::PosBits-1:0]),
    .eos_i  (s_axis_tlast_i),
    .jd_i   (jd_q),
    .step_o (step)
  );

  // Hold the open cluster; advance on each point transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      clu_q  <= '0;
    end else if (s_fire) begin
      open_q <= step.open;
      clu_q  <= step.clu;
    end
  end

  // Join distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jd_q <= rcpc_pkg::JoinDistanceReset;
    end else if (cfg_valid_i) begin
      jd_q <= cfg_data_i;
    end
  end

  assign push_n = s_fire ? step.push_n : 2'd0;

  rcpc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .row0_i   (step.row0),
    .row1_i   (step.row1),
    .space_o  (space),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .row_o    (out_row)
  );

  // Pack the result onto the master side
  assign m_axis_tdata_o = rcpc_pkg::OutDataBits'({out_row.clu.count, out_row.clu.high,
                                                  out_row.clu.low, out_row.clu.center});
  assign m_axis_tlast_o = out_row.last;
  assign m_axis_tuser_o = out_row.done;

  // An open cluster always has members and ordered bounds
  `RCPC_ASSERT(a_open_count, clk_i, rst_ni, !open_q || (clu_q.count != '0))
  `RCPC_ASSERT(a_open_bounds, clk_i, rst_ni, !open_q || (clu_q.low <= clu_q.high))
  // End of set leaves no cluster open
  `RCPC_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, s_fire && s_axis_tlast_i,
                    !open_q && (clu_q.count == '0))

endmodule

`default_nettype wire

>>> tb/running_center_point_clusterer_unit_tb.sv
// Self-checking testbench for running_center_point_clusterer_unit.
// Drives points on the slave stream, predicts clusters in a local model and
// checks every master-stream transfer; depends only on rcpc_pkg and the RTL.
`default_nettype none

module running_center_point_clusterer_unit_tb;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 9;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 4;
  localparam int TailCycles  = 10;
  localparam int PhaseItems  = 125;
  localparam int NumPhases   = 6;
  localparam logic [rcpc_pkg::PosBits-1:0] PosMax = '1;
  localparam logic [rcpc_pkg::IntBits-1:0] IntMax = '1;

  typedef enum logic {ROW_POINT, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    logic [rcpc_pkg::PosBits-1:0] data;
    logic                         eos;
    logic                         known;
    rcpc_pkg::result_t            known_res;
  } plan_row_t;

  // DUT connections
  logic                             clk_i     = 1'b0;
  logic                             rst_ni    = 1'b0;
  logic                             s_tvalid  = 1'b0;
  logic [rcpc_pkg::InDataBits-1:0]  s_tdata   = '0;
  logic                             s_tlast   = 1'b0;
  logic                             m_tready  = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [rcpc_pkg::JdBits-1:0]      cfg_data  = '0;
  logic                             s_axis_tready_o;
  logic                             m_axis_tvalid_o;
  logic [rcpc_pkg::OutDataBits-1:0] m_axis_tdata_o;
  logic                             m_axis_tlast_o;
  logic [0:0]                       m_axis_tuser_o;
  logic                             cfg_ready_o;

  // Predictor state
  logic                             cl_open;
  logic [rcpc_pkg::PosBits-1:0]     cl_center;
  logic [rcpc_pkg::IntBits-1:0]     cl_low;
  logic [rcpc_pkg::IntBits-1:0]     cl_high;
  logic [rcpc_pkg::CountBits-1:0]   cl_count;
  logic [rcpc_pkg::JdBits-1:0]      join_dist;

  // Expected clusters, oldest first
  rcpc_pkg::result_t pending_clusters[$];
  plan_row_t         plan[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stall_pct     = 0;
  int stall_left    = 0;
  int burst_left    = 0;
  int gap_len;
  bit gaps_on       = 1'b1;

  // Random stimulus scratch
  logic [63:0]       cur_pos, rnd64, thr64, dec;
  int                choice, set_len, phase_items, base_sel;
  logic              set_end;
  rcpc_pkg::result_t got, want;

  running_center_point_clusterer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: long hold-offs on request, otherwise stall at a changing rate
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        stall_left = $urandom_range(16, 96);
      end
      stall_left = stall_left - 1;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each output transfer with the oldest expected cluster
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.clu  = rcpc_pkg::cluster_t'(m_axis_tdata_o[rcpc_pkg::OutRawBits-1:0]);
      got.last = m_axis_tlast_o;
      got.done = m_axis_tuser_o[0];
      if (pending_clusters.size() == 0) begin
        fail_count = fail_count + 1;
        $display("%0t: unexpected cluster transfer %h", $time, got);
      end else begin
        want = pending_clusters.pop_front();
        if (got.clu.center !== want.clu.center) begin
          fail_count = fail_count + 1;
          $display("%0t: center expected %h actual %h", $time, want.clu.center,
                   got.clu.center);
        end
        if (got.clu.low !== want.clu.low) begin
          fail_count = fail_count + 1;
          $display("%0t: low expected %h actual %h", $time, want.clu.low, got.clu.low);
        end
        if (got.clu.high !== want.clu.high) begin
          fail_count = fail_count + 1;
          $display("%0t: high expected %h actual %h", $time, want.clu.high, got.clu.high);
        end
        if (got.clu.count !== want.clu.count) begin
          fail_count = fail_count + 1;
          $display("%0t: count expected %0d actual %0d", $time, want.clu.count,
                   got.clu.count);
        end
        if (got.last !== want.last) begin
          fail_count = fail_count + 1;
          $display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
        end
        if (got.done !== want.done) begin
          fail_count = fail_count + 1;
          $display("%0t: set_done expected %b actual %b", $time, want.done, got.done);
        end
      end
    end
  end

  // Append one expected cluster
  task automatic expect_cluster(input rcpc_pkg::result_t r);
    pending_clusters.insert(pending_clusters.size(), r);
  endtask

  // Start a one-point cluster
  task automatic open_cluster(input logic [rcpc_pkg::PosBits-1:0] pos);
    cl_open   = 1'b1;
    cl_center = pos;
    cl_low    = pos[rcpc_pkg::PosBits-1:rcpc_pkg::FracBits];
    cl_high   = pos[rcpc_pkg::PosBits-1:rcpc_pkg::FracBits];
    cl_count  = rcpc_pkg::CountBits'(1);
  endtask

  function automatic rcpc_pkg::result_t cluster_row(input logic last, input logic done);
    rcpc_pkg::result_t r;
    r.clu.center = cl_center;
    r.clu.low    = cl_low;
    r.clu.high   = cl_high;
    r.clu.count  = cl_count;
    r.last       = last;
    r.done       = done;
    return r;
  endfunction

  // Fold one point into the predicted cluster; return the clusters it emits
  task automatic fold_point(input logic [rcpc_pkg::PosBits-1:0] pos, input logic eos,
                            output int n, output rcpc_pkg::result_t r0,
                            output rcpc_pkg::result_t r1);
    logic [rcpc_pkg::IntBits-1:0] ip;
    logic                         joins;
    n  = 0;
    r0 = '0;
    r1 = '0;
    ip = pos[rcpc_pkg::PosBits-1:rcpc_pkg::FracBits];
    if (!cl_open) begin
      open_cluster(pos);
    end else begin
      // Points below the center always join
      joins = (pos < cl_center) ||
              ((pos - cl_center) < {join_dist, {rcpc_pkg::FracBits{1'b0}}});
      if (joins) begin
        cl_center = (cl_center >> 1) + (pos >> 1) +
                    {{(rcpc_pkg::PosBits-1){1'b0}}, cl_center[0] & pos[0]};
        if (ip < cl_low) cl_low = ip;
        if (ip > cl_high) cl_high = ip;
        if (cl_count != rcpc_pkg::CountMax) cl_count = cl_count + 1'b1;
      end else begin
        r0 = cluster_row(!eos, 1'b0);
        n  = 1;
        open_cluster(pos);
      end
    end
    // Flush the open cluster at the end of the set
    if (eos) begin
      if (n == 0) r0 = cluster_row(1'b1, 1'b1);
      else        r1 = cluster_row(1'b1, 1'b1);
      n         = n + 1;
      cl_open   = 1'b0;
      cl_center = '0;
      cl_low    = '0;
      cl_high   = '0;
      cl_count  = '0;
    end
  endtask

  // Offer one point, wait for the transfer, record its clusters, then idle after a burst if gaps are on
  task automatic offer_point(input logic [rcpc_pkg::PosBits-1:0] pos, input logic eos,
                             input logic known, input rcpc_pkg::result_t known_res);
    int                n;
    rcpc_pkg::result_t r0, r1;
    s_tvalid <= 1'b1;
    s_tdata  <= rcpc_pkg::InDataBits'(pos);
    s_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    fold_point(pos, eos, n, r0, r1);
    if (known) begin
      expect_cluster(known_res);
    end else begin
      if (n > 0) expect_cluster(r0);
      if (n > 1) expect_cluster(r1);
    end
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap_len    = $urandom_range(1, 6);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every expected cluster has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_clusters.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_distance(input logic [rcpc_pkg::JdBits-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    join_dist = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_point(input logic [rcpc_pkg::PosBits-1:0] data, input logic eos);
    plan_row_t row;
    row.kind      = ROW_POINT;
    row.data      = data;
    row.eos       = eos;
    row.known     = 1'b0;
    row.known_res = '0;
    plan.insert(plan.size(), row);
  endtask

  // Single-point set flushed at once: last and set_done are both set
  task automatic add_known(input logic [rcpc_pkg::PosBits-1:0] data,
                           input logic [rcpc_pkg::PosBits-1:0] center,
                           input logic [rcpc_pkg::IntBits-1:0] low,
                           input logic [rcpc_pkg::IntBits-1:0] high);
    plan_row_t row;
    row.kind                 = ROW_POINT;
    row.data                 = data;
    row.eos                  = 1'b1;
    row.known                = 1'b1;
    row.known_res.clu.center = center;
    row.known_res.clu.low    = low;
    row.known_res.clu.high   = high;
    row.known_res.clu.count  = rcpc_pkg::CountBits'(1);
    row.known_res.last       = 1'b1;
    row.known_res.done       = 1'b1;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_config(input logic [rcpc_pkg::JdBits-1:0] value);
    plan_row_t row;
    row.kind      = ROW_CONFIG;
    row.data      = rcpc_pkg::PosBits'(value);
    row.eos       = 1'b0;
    row.known     = 1'b0;
    row.known_res = '0;
    plan.insert(plan.size(), row);
  endtask

  initial begin
    cl_open   = 1'b0;
    cl_center = '0;
    cl_low    = '0;
    cl_high   = '0;
    cl_count  = '0;
    join_dist = rcpc_pkg::JoinDistanceReset;

    // Directed plan, starting from the reset distance of one
    add_known(40'h0, 40'h0, 32'h0, 32'h0);
    add_known(PosMax, PosMax, IntMax, IntMax);
    add_point(40'h100, 1'b0);                 // open
    add_point(40'h1FF, 1'b0);                 // just inside, joins
    add_point(40'h27F, 1'b0);                 // exactly at the distance, closes
    add_point(40'h200, 1'b0);                 // below the center, joins
    add_point(40'h10000, 1'b1);               // close and flush together
    add_point(40'h500, 1'b0);
    add_point(40'h5A0, 1'b1);                 // join and flush
    add_config(32'h0);                        // zero distance
    add_point(40'h800, 1'b0);
    add_point(40'h800, 1'b0);                 // equal to center, closes
    add_point(40'h7FF, 1'b0);                 // below the center still joins
    add_point(40'h7FF, 1'b1);
    add_config(IntMax);                       // widest distance
    add_point(40'h0, 1'b0);
    add_point(PosMax, 1'b0);                  // past the widest distance, closes
    add_point(40'hFF_FFFF_FEFF, 1'b0);
    add_point(40'h1, 1'b1);
    add_point(40'h0, 1'b0);
    add_point(40'hFF_FFFF_FEFF, 1'b1);        // just inside the widest distance
    add_config(32'h1);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        drain_results();
        write_distance(plan[i].data[rcpc_pkg::JdBits-1:0]);
      end else begin
        offer_point(plan[i].data, plan[i].eos, plan[i].known, plan[i].known_res);
      end
    end

    // Random sets, one distance per phase
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0:       write_distance(32'h1);
        1:       write_distance(rcpc_pkg::JdBits'($urandom_range(1, 8)));
        2:       write_distance(IntMax);
        3:       write_distance($urandom);
        4:       write_distance(rcpc_pkg::JdBits'($urandom_range(1, 300)));
        default: write_distance(rcpc_pkg::JdBits'($urandom_range(1, 3)));
      endcase
      thr64 = 64'(join_dist) << rcpc_pkg::FracBits;
      // Hold the receiver off while points keep coming back to back
      if (ph == 0 || ph == 3) begin
        hold_requests = hold_requests + 1;
        gaps_on       = 1'b0;
      end else begin
        gaps_on = (ph != 4);
      end
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        base_sel = $urandom_range(0, 3);
        rnd64    = {$urandom, $urandom};
        if (base_sel == 0)      cur_pos = rnd64 & 64'hFFFFF;
        else if (base_sel == 1) cur_pos = 64'(PosMax) - (rnd64 & 64'hFFFFF);
        else                    cur_pos = rnd64 & 64'(PosMax);
        set_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
        for (int k = 0; k < set_len; k++) begin
          if (k > 0) begin
            choice = $urandom_range(0, 99);
            rnd64  = {$urandom, $urandom};
            if (choice < 60) begin
              // Step within the distance
              if (thr64 != 0) cur_pos = cur_pos + (rnd64 % thr64);
            end else if (choice < 80) begin
              cur_pos = cur_pos + thr64 + 64'($urandom_range(0, 1023));
            end else if (choice < 88) begin
              // Step backward
              dec     = rnd64 % (thr64 + 64'd256);
              cur_pos = (cur_pos > dec) ? cur_pos - dec : 64'd0;
            end else if (choice < 95) begin
              // Step right at the distance boundary
              if (thr64 != 0) cur_pos = cur_pos + thr64 - 64'($urandom_range(0, 1));
            end else begin
              cur_pos = rnd64 & 64'(PosMax);
            end
            if (cur_pos > 64'(PosMax)) cur_pos = 64'(PosMax);
          end
          set_end = (k == set_len - 1) || ($urandom_range(0, 19) == 0);
          offer_point(cur_pos[rcpc_pkg::PosBits-1:0], set_end, 1'b0, '0);
          phase_items = phase_items + 1;
          if ((ph == 0 || ph == 3) && phase_items == 40) gaps_on = 1'b1;
        end
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> running_center_point_clusterer_unit.f
+incdir+rtl/core
rtl/core/rcpc_pkg.sv
rtl/core/rcpc_step.sv
rtl/core/rcpc_fifo.sv
rtl/core/running_center_point_clusterer_unit.sv
tb/running_center_point_clusterer_unit_tb.sv
